// ===== src/bpm_pkg.sv =====
// Shared constants, types, the battery voltage table and a helper function of the monitor.
package bpm_pkg;

    // Field widths.
    localparam int ADC_W      = 12;
    localparam int TIME_BITS  = 48;
    localparam int FULL_W     = 32;
    localparam int CHARGE_W   = 7;
    localparam int THR_W      = 7;
    localparam int BSM_W      = 2;
    localparam int MODE_W     = 2;
    localparam int LEVEL_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Voltage table geometry.
    localparam int TABLE_POINTS = 101;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int CELL_W       = ADC_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);
    localparam logic [IDX_W-1:0] MID_IDX  = IDX_W'((TABLE_POINTS - 1) / 2);

    // Charging estimate divider: the quotient never reaches 128.
    localparam int QUOT_W    = 7;
    localparam int NUM_W     = FULL_W + QUOT_W;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam logic [CHARGE_W-1:0] CHARGE_FULL  = CHARGE_W'(100);
    localparam logic [CHARGE_W-1:0] CHARGE_EMPTY = '0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_USB_DETECT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_THRESH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVING_MODE = 2'd3;

    // Configuration reset values.
    localparam logic [ADC_W-1:0]  RST_USB_DETECT  = ADC_W'(2200);
    localparam logic [FULL_W-1:0] RST_FULL_TIME   = FULL_W'(10800000);
    localparam logic [THR_W-1:0]  RST_SAVE_THRESH = THR_W'(25);
    localparam logic [BSM_W-1:0]  RST_SAVING_MODE = BSM_W'(1);

    // Supply state codes.
    localparam logic [MODE_W-1:0] SUPPLY_BATTERY  = 2'd0;
    localparam logic [MODE_W-1:0] SUPPLY_CHARGING = 2'd1;
    localparam logic [MODE_W-1:0] SUPPLY_CHARGED  = 2'd2;

    // Energy mode, period profile and long check period codes.
    localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REDUCED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOWEST  = 2'd2;

    // Charge level thresholds.
    localparam logic [CHARGE_W-1:0] LVL_T5 = CHARGE_W'(87);
    localparam logic [CHARGE_W-1:0] LVL_T4 = CHARGE_W'(62);
    localparam logic [CHARGE_W-1:0] LVL_T3 = CHARGE_W'(37);
    localparam logic [CHARGE_W-1:0] LVL_T2 = CHARGE_W'(12);
    localparam logic [CHARGE_W-1:0] LVL_T1 = CHARGE_W'(6);

    // Cell millivolts for 0 % up to 100 %.
    localparam logic [CELL_W-1:0] VOLT_TABLE [TABLE_POINTS] = '{
        13'd3200, 13'd3250, 13'd3300, 13'd3350, 13'd3400, 13'd3450, 13'd3500, 13'd3550,
        13'd3600, 13'd3650, 13'd3700, 13'd3703, 13'd3706, 13'd3710, 13'd3713, 13'd3716,
        13'd3719, 13'd3723, 13'd3726, 13'd3729, 13'd3732, 13'd3735, 13'd3739, 13'd3742,
        13'd3745, 13'd3748, 13'd3752, 13'd3755, 13'd3758, 13'd3761, 13'd3765, 13'd3768,
        13'd3771, 13'd3774, 13'd3777, 13'd3781, 13'd3784, 13'd3787, 13'd3790, 13'd3794,
        13'd3797, 13'd3800, 13'd3805, 13'd3811, 13'd3816, 13'd3821, 13'd3826, 13'd3832,
        13'd3837, 13'd3842, 13'd3847, 13'd3853, 13'd3858, 13'd3863, 13'd3868, 13'd3874,
        13'd3879, 13'd3884, 13'd3889, 13'd3895, 13'd3900, 13'd3906, 13'd3911, 13'd3917,
        13'd3922, 13'd3928, 13'd3933, 13'd3939, 13'd3944, 13'd3950, 13'd3956, 13'd3961,
        13'd3967, 13'd3972, 13'd3978, 13'd3983, 13'd3989, 13'd3994, 13'd4000, 13'd4008,
        13'd4015, 13'd4023, 13'd4031, 13'd4038, 13'd4046, 13'd4054, 13'd4062, 13'd4069,
        13'd4077, 13'd4085, 13'd4092, 13'd4100, 13'd4111, 13'd4122, 13'd4133, 13'd4144,
        13'd4156, 13'd4167, 13'd4178, 13'd4189, 13'd4200
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_prep;
        logic div_step;
        logic search_step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic need_search;
        logic search_done;
    } t_status;

    // One result item.
    typedef struct packed {
        logic [MODE_W-1:0]   supply_mode;
        logic [CHARGE_W-1:0] charge_percent;
        logic [LEVEL_W-1:0]  charge_level;
        logic                charging_icon;
        logic [MODE_W-1:0]   energy_mode;
        logic [MODE_W-1:0]   period_profile;
        logic [MODE_W-1:0]   voltage_check_long;
        logic                auto_backlight_off;
        logic                usb_attach_event;
        logic                usb_detach_event;
    } t_result;

    // Six-step icon code of a charge percent.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [CHARGE_W-1:0] c);
        logic [LEVEL_W-1:0] lvl;
        if (c > LVL_T5)      lvl = LEVEL_W'(5);
        else if (c > LVL_T4) lvl = LEVEL_W'(4);
        else if (c > LVL_T3) lvl = LEVEL_W'(3);
        else if (c > LVL_T2) lvl = LEVEL_W'(2);
        else if (c > LVL_T1) lvl = LEVEL_W'(1);
        else                 lvl = LEVEL_W'(0);
        return lvl;
    endfunction

endpackage

// ===== src/bpm_channels.sv =====
// Valid/ready channel interfaces for check events and monitor results.
interface bpm_in_if import bpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADC_W-1:0]     adc_mv;
    logic [TIME_BITS-1:0] now_ms;
    logic                 display_on;

    modport source(output valid, adc_mv, now_ms, display_on, input ready);
    modport sink(input valid, adc_mv, now_ms, display_on, output ready);
endinterface

interface bpm_out_if import bpm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   supply_mode;
    logic [CHARGE_W-1:0] charge_percent;
    logic [LEVEL_W-1:0]  charge_level;
    logic                charging_icon;
    logic [MODE_W-1:0]   energy_mode;
    logic [MODE_W-1:0]   period_profile;
    logic [MODE_W-1:0]   voltage_check_long;
    logic                auto_backlight_off;
    logic                usb_attach_event;
    logic                usb_detach_event;

    modport source(output valid, supply_mode, charge_percent, charge_level, charging_icon,
                   energy_mode, period_profile, voltage_check_long, auto_backlight_off,
                   usb_attach_event, usb_detach_event, input ready);
    modport sink(input valid, supply_mode, charge_percent, charge_level, charging_icon,
                 energy_mode, period_profile, voltage_check_long, auto_backlight_off,
                 usb_attach_event, usb_detach_event, output ready);
endinterface

// ===== src/bpm_ctrl.sv =====
// Controller state machine that sequences evaluation, division, table search and commit.
module bpm_ctrl import bpm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_PREP   = 6'b000100,
        S_DIV    = 6'b001000,
        S_SEARCH = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                  r_out_valid, n_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.need_div) begin
                    n_state = S_PREP;
                end else if (i_status.need_search) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_status.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register is full after a commit until its transfer.
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/bpm_datapath.sv =====
// Datapath: configuration, monitor state, restoring divider, table search and result register.
module bpm_datapath import bpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADC_W-1:0]      i_adc_mv,
    input  logic [TIME_BITS-1:0]  i_now_ms,
    input  logic                  i_display_on,
    output t_result               o_result
);

    // Configuration registers.
    logic [ADC_W-1:0]     r_usb_mv;
    logic [FULL_W-1:0]    r_full_ms;
    logic [THR_W-1:0]     r_thr;
    logic [BSM_W-1:0]     r_bsm;

    // Monitor state.
    logic [MODE_W-1:0]    r_supply;
    logic [TIME_BITS-1:0] r_start;
    logic [CHARGE_W-1:0]  r_last;
    logic [MODE_W-1:0]    r_saving;
    logic                 r_flag;

    // Latched event and per-event working registers.
    logic [ADC_W-1:0]     r_adc;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_disp;
    logic                 r_is_usb;
    logic                 r_attach;
    logic [MODE_W-1:0]    r_supply_next;
    logic                 r_use_div;
    logic [FULL_W-1:0]    r_e32;
    logic [CHARGE_W-1:0]  r_charge;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_before;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [QUOT_W-1:0]    r_quot;
    t_result              r_result;

    logic                 w_usb;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_charged;
    logic                 w_attach;
    logic [MODE_W-1:0]    w_supply_next;
    logic [CELL_W-1:0]    w_cell;
    logic                 w_hi;
    logic                 w_lo;
    logic [IDX_W-1:0]     w_dist;
    logic [IDX_W-1:0]     w_step;
    logic [IDX_W:0]       w_up_sum;
    logic [IDX_W-1:0]     w_next;
    logic [NUM_W-1:0]     w_e_ext;
    logic                 w_ge;
    logic [CHARGE_W:0]    w_csum;
    logic [CHARGE_W-1:0]  w_charge;
    logic                 w_above;
    t_result              w_res;

    // Supply decision for the latched event.
    assign w_usb         = (r_adc >= r_usb_mv);
    assign w_elapsed     = r_now - r_start;
    assign w_charged     = (r_supply != SUPPLY_BATTERY) && (w_elapsed >= TIME_BITS'(r_full_ms));
    assign w_attach      = w_usb && (r_supply == SUPPLY_BATTERY);
    assign w_supply_next = w_attach ? SUPPLY_CHARGING :
                           (w_charged ? SUPPLY_CHARGED : r_supply);

    // Battery table range checks on the cell voltage.
    assign w_cell = {r_adc, 1'b0};
    assign w_hi   = (w_cell >= VOLT_TABLE[TABLE_POINTS-1]);
    assign w_lo   = (w_cell <= VOLT_TABLE[0]);

    // One halving step of the table search.
    assign w_dist   = (r_idx > r_before) ? (r_idx - r_before) : (r_before - r_idx);
    assign w_step   = w_dist >> 1;
    assign w_up_sum = {1'b0, r_idx} + {1'b0, w_step};
    always_comb begin
        if (w_cell >= VOLT_TABLE[r_idx]) begin
            w_next = (w_up_sum > {1'b0, LAST_IDX}) ? LAST_IDX : w_up_sum[IDX_W-1:0];
        end else begin
            w_next = (w_step > r_idx) ? '0 : (r_idx - w_step);
        end
    end

    assign o_status.need_div    = w_usb && (w_supply_next == SUPPLY_CHARGING) && (r_full_ms != '0);
    assign o_status.need_search = !w_usb && !w_hi && !w_lo;
    assign o_status.search_done = (w_next == r_idx);

    // Divider step: elapsed*100 over the full charge time, one quotient bit a cycle.
    assign w_e_ext = NUM_W'(r_e32);
    assign w_ge    = (r_rem >= r_dsh);

    // Charge of this event and its saturated charging sum.
    assign w_csum   = {1'b0, r_last} + {1'b0, r_quot};
    assign w_charge = r_use_div ? ((w_csum > {1'b0, CHARGE_FULL}) ? CHARGE_FULL
                                                                  : w_csum[CHARGE_W-1:0])
                                : r_charge;
    assign w_above  = (w_charge >= r_thr);

    // Result fields of the event.
    always_comb begin
        w_res                    = '0;
        w_res.charge_percent     = w_charge;
        w_res.charge_level       = level_of(w_charge);
        w_res.charging_icon      = r_is_usb;
        if (r_is_usb) begin
            w_res.supply_mode        = r_supply_next;
            w_res.energy_mode        = r_attach ? MODE_FULL : r_saving;
            w_res.period_profile     = MODE_FULL;
            w_res.voltage_check_long = MODE_FULL;
            w_res.auto_backlight_off = r_attach ? 1'b0 : r_flag;
            w_res.usb_attach_event   = r_attach;
        end else begin
            w_res.supply_mode        = SUPPLY_BATTERY;
            w_res.auto_backlight_off = (r_saving == MODE_FULL) ? 1'b1 : r_flag;
            w_res.usb_detach_event   = (r_saving == MODE_FULL);
            if (w_above) begin
                w_res.energy_mode        = r_bsm[1] ? MODE_LOWEST : MODE_REDUCED;
                w_res.period_profile     = MODE_REDUCED;
                w_res.voltage_check_long = r_disp ? MODE_FULL : MODE_REDUCED;
            end else begin
                w_res.energy_mode        = MODE_LOWEST;
                w_res.period_profile     = MODE_LOWEST;
                w_res.voltage_check_long = r_disp ? MODE_FULL : MODE_LOWEST;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usb_mv  <= RST_USB_DETECT;
            r_full_ms <= RST_FULL_TIME;
            r_thr     <= RST_SAVE_THRESH;
            r_bsm     <= RST_SAVING_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_USB_DETECT:  r_usb_mv  <= i_cfg_data[ADC_W-1:0];
                CFG_FULL_TIME:   r_full_ms <= i_cfg_data[FULL_W-1:0];
                CFG_SAVE_THRESH: r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_SAVING_MODE: r_bsm     <= i_cfg_data[BSM_W-1:0];
                default: ;
            endcase
        end
    end

    // Monitor state is updated when the result is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_BATTERY;
            r_start  <= '0;
            r_last   <= '0;
            r_saving <= MODE_FULL;
            r_flag   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_supply <= w_res.supply_mode;
            r_saving <= w_res.energy_mode;
            r_flag   <= w_res.auto_backlight_off;
            if (r_is_usb) begin
                if (r_attach) begin
                    r_start <= r_now;
                end
            end else begin
                r_start <= '0;
                r_last  <= w_charge;
            end
        end
    end

    // Working registers of the event.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_adc  <= i_adc_mv;
            r_now  <= i_now_ms;
            r_disp <= i_display_on;
        end
        if (i_cmd.eval) begin
            r_is_usb      <= w_usb;
            r_attach      <= w_attach;
            r_supply_next <= w_supply_next;
            r_use_div     <= o_status.need_div;
            r_e32         <= w_attach ? '0 : w_elapsed[FULL_W-1:0];
            r_idx         <= MID_IDX;
            r_before      <= '0;
            if (w_usb || w_hi) begin
                r_charge <= CHARGE_FULL;
            end else begin
                r_charge <= CHARGE_EMPTY;
            end
        end
        if (i_cmd.div_prep) begin
            r_rem  <= (w_e_ext << 6) + (w_e_ext << 5) + (w_e_ext << 2);
            r_dsh  <= NUM_W'(r_full_ms) << (QUOT_W - 1);
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
        if (i_cmd.search_step) begin
            r_before <= r_idx;
            r_idx    <= w_next;
            r_charge <= CHARGE_W'(w_next);
        end
        if (i_cmd.commit) begin
            r_result <= w_res;
        end
    end

    assign o_result = r_result;

endmodule

// ===== src/battery_power_mode_monitor_top.sv =====
// Top level of the battery power mode monitor: controller, datapath and channel wiring.
// Steps from input transfer to result: evaluate and finish on battery outside the table range
// or when charged, with the table search in between inside the table range, and with the
// divider setup and the charging divider in between, which resolves one quotient bit per cycle.
// Throughput: one event at a time; the input is ready again the cycle after the commit.
// Reset (synchronous, active low) restores the default configuration and battery state.
module battery_power_mode_monitor_top import bpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpm_in_if.sink                i_in,
    bpm_out_if.source             o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;

    bpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bpm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_adc_mv     (i_in.adc_mv),
        .i_now_ms     (i_in.now_ms),
        .i_display_on (i_in.display_on),
        .o_result     (w_result)
    );

    // Result fields onto the output channel.
    assign o_out.supply_mode        = w_result.supply_mode;
    assign o_out.charge_percent     = w_result.charge_percent;
    assign o_out.charge_level       = w_result.charge_level;
    assign o_out.charging_icon      = w_result.charging_icon;
    assign o_out.energy_mode        = w_result.energy_mode;
    assign o_out.period_profile     = w_result.period_profile;
    assign o_out.voltage_check_long = w_result.voltage_check_long;
    assign o_out.auto_backlight_off = w_result.auto_backlight_off;
    assign o_out.usb_attach_event   = w_result.usb_attach_event;
    assign o_out.usb_detach_event   = w_result.usb_detach_event;

endmodule

// ===== src/bpm_checker.sv =====
// Port-level assertions on the monitor, bound to its top level.
module bpm_checker import bpm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [MODE_W-1:0]   i_supply_mode,
    input logic [CHARGE_W-1:0] i_charge_percent,
    input logic [LEVEL_W-1:0]  i_charge_level,
    input logic                i_charging_icon,
    input logic [MODE_W-1:0]   i_energy_mode,
    input logic                i_auto_backlight_off,
    input logic                i_usb_attach_event
);

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_charge_percent) && $stable(i_supply_mode)))
        else $error("result changed while stalled");

    // One event at a time: no input transfer right after another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // Charged on USB always reports a full battery.
    a_charged_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_supply_mode == SUPPLY_CHARGED) |->
            (i_charge_percent == CHARGE_FULL && i_charge_level == LEVEL_W'(5)))
        else $error("charged state without full charge");

    // The charging icon follows USB power.
    a_icon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_charging_icon == (i_supply_mode != SUPPLY_BATTERY)))
        else $error("charging icon disagrees with supply mode");

    // An attach starts charging in full energy with the backlight timer off.
    a_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_usb_attach_event) |->
            (i_supply_mode == SUPPLY_CHARGING && i_energy_mode == MODE_FULL
             && !i_auto_backlight_off))
        else $error("attach event with wrong modes");

endmodule

bind battery_power_mode_monitor_top bpm_checker u_bpm_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_supply_mode        (o_out.supply_mode),
    .i_charge_percent     (o_out.charge_percent),
    .i_charge_level       (o_out.charge_level),
    .i_charging_icon      (o_out.charging_icon),
    .i_energy_mode        (o_out.energy_mode),
    .i_auto_backlight_off (o_out.auto_backlight_off),
    .i_usb_attach_event   (o_out.usb_attach_event)
);
